>>> src/uass_pkg.sv
// Shared types and codes for the automaton state-set stepper.
// No dependencies; the top, checker and testbench take names from here by scope.
package uass_pkg;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;
  localparam logic [1:0] ACT_SET     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

endpackage

>>> src/uass_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uass_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/universal_automaton_stateset_stepper_top.sv
// Top level of the automaton state-set stepper: control, state registers, table RAM.
// Depends on uass_pkg and uass_ram.
//
// Load, restart and set: result strobed in the cycle after acceptance, one word per cycle.
// Step: busy through the scan and drain states, result in the cycle after drain;
//   the single table read port scans one state per cycle.
// A step on a failed walk or an unknown letter answers at once, like a load.
// Reset (rst, synchronous): set = start state 0 only, no failure, start_state = 0.
// Table contents stay undefined until loaded; no clearing pass. Results cannot be stalled.
module universal_automaton_stateset_stepper_top #(
  parameter int STATE_COUNT  = 32,
  parameter int LETTER_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [4:0]  state_index,
  input  logic [3:0]  letter,
  input  logic [31:0] next_mask,
  input  logic        entry_fails,
  // result channel
  output logic        done,
  output logic        walk_failed,
  output logic [31:0] active_set,
  // configuration channel: start_state
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  localparam int DEPTH = STATE_COUNT * LETTER_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(STATE_COUNT);
  localparam logic [IW-1:0] LAST = IW'(STATE_COUNT - 1);

  uass_pkg::state_t state;

  logic [STATE_COUNT-1:0] cur_set;
  logic                   failed;
  logic [4:0]             start_state;

  // step scan registers
  logic [IW-1:0]          idx;
  logic [3:0]             step_letter;
  logic [STATE_COUNT-1:0] acc;
  logic                   hit;
  logic                   pend;     // word on rdata belongs to an active state

  logic                   accept;
  logic                   letter_ok;
  logic                   load_ok;
  logic [STATE_COUNT-1:0] start_set;
  logic [STATE_COUNT-1:0] in_set;
  logic [STATE_COUNT-1:0] final_acc;
  logic                   final_hit;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [STATE_COUNT:0]   ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [STATE_COUNT:0]   ram_rdata;

  assign busy      = (state != uass_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign letter_ok = (32'(letter) < 32'(LETTER_COUNT));
  assign load_ok   = letter_ok && (32'(state_index) < 32'(STATE_COUNT));

  // Mask to the state count: truncate or zero-extend the 32-bit word.
  assign in_set    = STATE_COUNT'(next_mask);
  assign start_set = (32'(start_state) < 32'(STATE_COUNT))
                     ? (STATE_COUNT'(1) << start_state) : '0;

  // Table: one row of LETTER_COUNT entries per source state; fail mark on top.
  assign ram_we    = accept && (action == uass_pkg::ACT_LOAD) && load_ok;
  assign ram_waddr = AW'(32'(state_index) * 32'(LETTER_COUNT) + 32'(letter));
  assign ram_wdata = {entry_fails, in_set};
  assign ram_re    = (state == uass_pkg::S_SCAN);
  assign ram_raddr = AW'(32'(idx) * 32'(LETTER_COUNT) + 32'(step_letter));

  uass_ram #(
    .WIDTH (STATE_COUNT + 1),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Fold in the last table word still in flight when the scan ends.
  assign final_acc = acc | (pend ? ram_rdata[STATE_COUNT-1:0] : '0);
  assign final_hit = hit | (pend & ram_rdata[STATE_COUNT]);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_state <= cfg_data;
    end
  end

  // Control, walk state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= uass_pkg::S_IDLE;
      done    <= 1'b0;
      cur_set <= STATE_COUNT'(1);
      failed  <= 1'b0;
      idx     <= '0;
      pend    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        uass_pkg::S_IDLE: begin
          if (accept) begin
            unique case (action)
              uass_pkg::ACT_LOAD: begin
                // table write happens on the RAM port; report unchanged walk
                done        <= 1'b1;
                walk_failed <= failed;
                active_set  <= failed ? 32'd0 : 32'(cur_set);
              end
              uass_pkg::ACT_STEP: begin
                if (!failed && letter_ok) begin
                  state       <= uass_pkg::S_SCAN;
                  idx         <= '0;
                  step_letter <= letter;
                  acc         <= '0;
                  hit         <= 1'b0;
                  pend        <= 1'b0;
                end else begin
                  // hold the walk: failed is sticky, unknown letters are dropped
                  done        <= 1'b1;
                  walk_failed <= failed;
                  active_set  <= failed ? 32'd0 : 32'(cur_set);
                end
              end
              uass_pkg::ACT_RESTART: begin
                cur_set     <= start_set;
                failed      <= 1'b0;
                done        <= 1'b1;
                walk_failed <= 1'b0;
                active_set  <= 32'(start_set);
              end
              uass_pkg::ACT_SET: begin
                cur_set     <= in_set;
                failed      <= 1'b0;
                done        <= 1'b1;
                walk_failed <= 1'b0;
                active_set  <= 32'(in_set);
              end
              default: ;
            endcase
          end
        end
        uass_pkg::S_SCAN: begin
          // Issue a read for state idx; accumulate the word read last cycle.
          pend <= cur_set[idx];
          if (pend) begin
            acc <= acc | ram_rdata[STATE_COUNT-1:0];
            hit <= hit | ram_rdata[STATE_COUNT];
          end
          if (idx == LAST) begin
            state <= uass_pkg::S_DRAIN;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        uass_pkg::S_DRAIN: begin
          pend  <= 1'b0;
          done  <= 1'b1;
          state <= uass_pkg::S_IDLE;
          if (final_hit) begin
            failed      <= 1'b1;
            cur_set     <= '0;
            walk_failed <= 1'b1;
            active_set  <= 32'd0;
          end else begin
            cur_set     <= final_acc;
            walk_failed <= 1'b0;
            active_set  <= 32'(final_acc);
          end
        end
        default: begin
          state <= uass_pkg::S_IDLE;
        end
      endcase
    end
  end

  // The drain cycle always ends in exactly one result word.
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == uass_pkg::S_DRAIN) |=> (done && (state == uass_pkg::S_IDLE)))
    else $error("drain did not produce a result");

  // The scan leaves after the last state has been read.
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == uass_pkg::S_SCAN && idx == LAST) |=> (state == uass_pkg::S_DRAIN))
    else $error("scan overran the last state");

  // A failed walk reports an empty set.
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (done && walk_failed) |-> (active_set == 32'd0))
    else $error("failed walk reported a non-empty set");

  // A step on a failed walk answers at once and stays failed.
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == uass_pkg::ACT_STEP) && failed) |=> (done && walk_failed && !busy))
    else $error("failure was not sticky");

endmodule

>>> sim/uass_walk_checker.sv
// Checker for the automaton state-set stepper: watches the command, result and
// start_state channels, predicts each result word and compares it field by field.
// Depends on uass_pkg for the action codes.
module uass_walk_checker #(
  parameter int STATE_COUNT  = 32,
  parameter int LETTER_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [4:0]  state_index,
  input  logic [3:0]  letter,
  input  logic [31:0] next_mask,
  input  logic        entry_fails,
  input  logic        done,
  input  logic        walk_failed,
  input  logic [31:0] active_set,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          fault_count,
  output int          words_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = STATE_COUNT * LETTER_COUNT;
  localparam logic [31:0] STATE_BITS =
    (STATE_COUNT >= 32) ? 32'hFFFF_FFFF : ((32'd1 << STATE_COUNT) - 32'd1);

  typedef struct packed {
    logic        failed;
    logic [31:0] set;
  } walk_word_t;

  walk_word_t  pending_walks[$];
  logic [31:0] succ_mask [TABLE_DEPTH];
  logic        fail_mark [TABLE_DEPTH];
  logic [31:0] live_set;
  logic        dead;
  logic [4:0]  home_state;

  function automatic logic [31:0] home_set();
    return (home_state < STATE_COUNT) ? (32'd1 << home_state) : 32'd0;
  endfunction

  // Apply one command word to the shadow walk and return the word it answers with.
  function automatic walk_word_t advance_walk(input logic [1:0] act, input logic [4:0] src,
                                              input logic [3:0] ltr, input logic [31:0] mask,
                                              input logic fails);
    int          idx;
    logic [31:0] acc;
    logic        hit;
    walk_word_t  w;
    case (act)
      uass_pkg::ACT_LOAD: begin
        if (src < STATE_COUNT && ltr < LETTER_COUNT) begin
          idx            = src * LETTER_COUNT + ltr;
          succ_mask[idx] = mask & STATE_BITS;
          fail_mark[idx] = fails;
        end
      end
      uass_pkg::ACT_STEP: begin
        if (!dead && ltr < LETTER_COUNT) begin
          acc = '0;
          hit = 1'b0;
          for (int s = 0; s < STATE_COUNT && s < 32; s++) begin
            if (live_set[s]) begin
              idx = s * LETTER_COUNT + ltr;
              hit = hit | fail_mark[idx];
              acc = acc | succ_mask[idx];
            end
          end
          if (hit) begin
            dead     = 1'b1;
            live_set = '0;
          end else begin
            live_set = acc & STATE_BITS;
          end
        end
      end
      uass_pkg::ACT_RESTART: begin
        live_set = home_set();
        dead     = 1'b0;
      end
      uass_pkg::ACT_SET: begin
        live_set = mask & STATE_BITS;
        dead     = 1'b0;
      end
    endcase
    w.failed = dead;
    w.set    = dead ? 32'd0 : live_set;
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    fault_count++;
    if (fault_count <= 50) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    walk_word_t want;
    walk_word_t fresh;
    if (rst) begin
      home_state = '0;
      dead       = 1'b0;
      live_set   = home_set();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        succ_mask[i] = '0;
        fail_mark[i] = 1'b0;
      end
      pending_walks.delete();
    end else begin
      if (done) begin
        if (pending_walks.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = pending_walks.pop_front();
          if (walk_failed !== want.failed)
            report_mismatch($sformatf("walk_failed %b, predicted %b", walk_failed, want.failed));
          if (active_set !== want.set)
            report_mismatch($sformatf("active_set %h, predicted %h", active_set, want.set));
        end
      end
      // the block samples start_state before a write at the same edge lands
      if (start && !busy) begin
        fresh         = advance_walk(action, state_index, letter, next_mask, entry_fails);
        pending_walks = {pending_walks, fresh};
      end
      if (cfg_valid && cfg_ready) home_state = cfg_data;
    end
    words_outstanding = pending_walks.size();
  end

endmodule

>>> sim/testbench.sv
// Top of the stepper testbench: clock, reset, command and start_state stimulus, verdict.
// Depends on uass_pkg, universal_automaton_stateset_stepper_top and uass_walk_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STATE_COUNT  = 32;
  localparam int LETTER_COUNT = 16;
  // Generous ceiling: a step keeps the block busy for a full table scan, plus sender gaps.
  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = uass_pkg::ACT_LOAD;
  logic [4:0]  state_index = '0;
  logic [3:0]  letter = '0;
  logic [31:0] next_mask = '0;
  logic        entry_fails = 1'b0;
  logic        done;
  logic        walk_failed;
  logic [31:0] active_set;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;

  int fault_count;
  int words_outstanding;
  int gap_pct = 15;
  int cycle_count = 0;

  always #1 clk = ~clk;

  universal_automaton_stateset_stepper_top #(
    .STATE_COUNT  (STATE_COUNT),
    .LETTER_COUNT (LETTER_COUNT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .state_index (state_index),
    .letter      (letter),
    .next_mask   (next_mask),
    .entry_fails (entry_fails),
    .done        (done),
    .walk_failed (walk_failed),
    .active_set  (active_set),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  uass_walk_checker #(
    .STATE_COUNT  (STATE_COUNT),
    .LETTER_COUNT (LETTER_COUNT)
  ) u_checker (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .action            (action),
    .state_index       (state_index),
    .letter            (letter),
    .next_mask         (next_mask),
    .entry_fails       (entry_fails),
    .done              (done),
    .walk_failed       (walk_failed),
    .active_set        (active_set),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .fault_count       (fault_count),
    .words_outstanding (words_outstanding)
  );

  // Watchdog: abandon the run if it hangs anywhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly sparse masks so that walks stay narrow and the fail marks bite now and then;
  // the odd empty, full or dense mask keeps every bit moving.
  function automatic logic [31:0] pick_mask();
    int k;
    k = $urandom_range(19);
    if (k == 0) return 32'd0;
    if (k == 1) return 32'hFFFF_FFFF;
    if (k < 10) return 32'd1 << $urandom_range(31);
    if (k < 15) return (32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  // Present one command word and hold it until the block takes it. Called and left at a
  // rising edge; start stays high on return so that back-to-back words need no toggle.
  task automatic send_word(input logic [1:0] act, input logic [4:0] src,
                           input logic [3:0] ltr, input logic [31:0] mask,
                           input logic fails);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start       <= 1'b1;
    action      <= act;
    state_index <= src;
    letter      <= ltr;
    next_mask   <= mask;
    entry_fails <= fails;
    // busy is settled by the falling edge; the following rising edge accepts the word
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // One random word once the whole table has been written, so any step is legal.
  // Unused fields carry noise; the block must ignore them.
  task automatic random_word();
    int          r;
    logic [1:0]  act;
    logic [31:0] mask;
    logic        fails;
    r     = $urandom_range(99);
    mask  = $urandom;
    fails = 1'($urandom_range(1));
    if (r < 25) begin
      act   = uass_pkg::ACT_LOAD;
      mask  = pick_mask();
      fails = ($urandom_range(24) == 0);
    end else if (r < 70) begin
      act = uass_pkg::ACT_STEP;
    end else if (r < 82) begin
      act = uass_pkg::ACT_RESTART;
    end else begin
      act  = uass_pkg::ACT_SET;
      mask = pick_mask();
    end
    send_word(act, 5'($urandom_range(31)), 4'($urandom_range(15)), mask, fails);
  endtask

  // Drop start and hold until every predicted word has come back.
  task automatic drain_words();
    start <= 1'b0;
    do @(negedge clk); while (words_outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_start_state(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_start_state(5'd0);

    // Directed words. The walk starts from state 0 alone; only entries already
    // loaded are ever stepped through.
    send_word(uass_pkg::ACT_RESTART, 5'd0,  4'd0,  32'h0000_0000, 1'b0);
    send_word(uass_pkg::ACT_LOAD,    5'd0,  4'd0,  32'hFFFF_FFFF, 1'b0);
    send_word(uass_pkg::ACT_LOAD,    5'd0,  4'd15, 32'h8000_0001, 1'b0);
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd15, 32'h0000_0000, 1'b0);  // {0} -> {0,31}
    send_word(uass_pkg::ACT_LOAD,    5'd31, 4'd15, 32'h0000_0000, 1'b0);
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd15, 32'h0000_0000, 1'b0);  // union of both
    send_word(uass_pkg::ACT_LOAD,    5'd31, 4'd0,  32'h0000_0000, 1'b1);  // fail mark, top
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd0,  32'h0000_0000, 1'b0);  // failing step
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd0,  32'h0000_0000, 1'b0);  // stays put
    send_word(uass_pkg::ACT_LOAD,    5'd5,  4'd3,  32'h1234_5678, 1'b0);  // load while failed
    send_word(uass_pkg::ACT_SET,     5'd0,  4'd0,  32'h0000_0000, 1'b0);  // empty, cleared
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd9,  32'h0000_0000, 1'b0);  // step from nothing
    send_word(uass_pkg::ACT_SET,     5'd0,  4'd0,  32'hFFFF_FFFF, 1'b0);
    send_word(uass_pkg::ACT_RESTART, 5'd0,  4'd0,  32'h0000_0000, 1'b0);
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd0,  32'h0000_0000, 1'b0);  // {0} -> every state
    send_word(uass_pkg::ACT_SET,     5'd0,  4'd0,  32'h8000_0000, 1'b0);
    send_word(uass_pkg::ACT_LOAD,    5'd31, 4'd15, 32'h5555_AAAA, 1'b0);
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd15, 32'h0000_0000, 1'b0);
    drain_words();

    // Highest start state: restart lands on state 31 alone, then walk one letter.
    write_start_state(5'd31);
    send_word(uass_pkg::ACT_RESTART, 5'd0,  4'd0,  32'h0000_0000, 1'b0);
    send_word(uass_pkg::ACT_STEP,    5'd0,  4'd15, 32'h0000_0000, 1'b0);
    drain_words();

    // Phase one: light sender gaps. Write every table entry with random content
    // first, so that random steps never read an entry that was not loaded.
    write_start_state(5'($urandom_range(30, 1)));
    gap_pct = 15;
    for (int s = 0; s < STATE_COUNT; s++) begin
      for (int l = 0; l < LETTER_COUNT; l++) begin
        send_word(uass_pkg::ACT_LOAD, 5'(s), 4'(l), pick_mask(), ($urandom_range(24) == 0));
      end
    end
    repeat (180) random_word();
    drain_words();

    // Phase two: heavy sender gaps.
    write_start_state(5'd0);
    gap_pct = 77;
    repeat (170) random_word();
    drain_words();

    // Phase three: back-to-back words.
    write_start_state(5'd31);
    gap_pct = 0;
    repeat (170) random_word();
    drain_words();

    // Allow for anything still in flight, then give the verdict.
    repeat (STATE_COUNT + 8) @(posedge clk);
    if (fault_count == 0 && words_outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
